[src/shape_vertex_generator_defines.svh]
// ----------------------------------------------------------------------------
// shape_vertex_generator_defines.svh
// assertion macros used by the shape vertex generator checker
// ----------------------------------------------------------------------------
`ifndef SHAPE_VERTEX_GENERATOR_DEFINES_SVH
`define SHAPE_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define SVG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/svg_pkg.sv]
// ----------------------------------------------------------------------------
// svg_pkg
// types, constants and tables of the shape vertex generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svg_pkg;

  localparam int MAX_SEGMENTS   = 63;
  localparam int BEZIER_SAMPLES = 8;
  localparam int FRAC_BITS      = 8;
  localparam int RECT_RESULTS   = 6;

  localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W  = SEG_W;
  localparam int BZ_IW  = $clog2(BEZIER_SAMPLES);
  localparam int BZ_SH  = 3 * BZ_IW;
  localparam int BZ_W_W = BZ_SH + 1;
  localparam int BZ_ACC_W = BZ_W_W + 16;
  localparam int RND_SH = 30 - FRAC_BITS;

  localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

  localparam int DIV_W     = 40;
  localparam int DVS_W     = 8;
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_CIRCLE = 2'd0;
  localparam logic [1:0] KIND_RECT   = 2'd1;
  localparam logic [1:0] KIND_BEZIER = 2'd2;

  localparam logic [2:0] REG_KIND   = 3'd0;
  localparam logic [2:0] REG_SIZE_A = 3'd1;
  localparam logic [2:0] REG_SIZE_B = 3'd2;
  localparam logic [2:0] REG_BZ0    = 3'd3;
  localparam logic [2:0] REG_BZ1    = 3'd4;
  localparam logic [2:0] REG_BZ2    = 3'd5;
  localparam logic [2:0] REG_BZ3    = 3'd6;

  localparam logic [4:0] OP_NONE    = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_PH_DIV  = 5'd2;
  localparam logic [4:0] OP_PH_WB   = 5'd3;
  localparam logic [4:0] OP_MUL_X   = 5'd4;
  localparam logic [4:0] OP_WB_X    = 5'd5;
  localparam logic [4:0] OP_MUL_X2  = 5'd6;
  localparam logic [4:0] OP_WB_X2   = 5'd7;
  localparam logic [4:0] OP_MUL_TS  = 5'd8;
  localparam logic [4:0] OP_DIV_TS  = 5'd9;
  localparam logic [4:0] OP_WB_TS   = 5'd10;
  localparam logic [4:0] OP_MUL_TC  = 5'd11;
  localparam logic [4:0] OP_DIV_TC  = 5'd12;
  localparam logic [4:0] OP_WB_TC   = 5'd13;
  localparam logic [4:0] OP_QUAD    = 5'd14;
  localparam logic [4:0] OP_MUL_OX  = 5'd15;
  localparam logic [4:0] OP_WB_OX   = 5'd16;
  localparam logic [4:0] OP_MUL_OY  = 5'd17;
  localparam logic [4:0] OP_WB_OY   = 5'd18;
  localparam logic [4:0] OP_EMIT_C  = 5'd19;
  localparam logic [4:0] OP_CLOSE   = 5'd20;
  localparam logic [4:0] OP_RECT    = 5'd21;
  localparam logic [4:0] OP_BZ_CLR  = 5'd22;
  localparam logic [4:0] OP_BZ_MX   = 5'd23;
  localparam logic [4:0] OP_BZ_MY   = 5'd24;
  localparam logic [4:0] OP_BZ_ACC  = 5'd25;
  localparam logic [4:0] OP_BZ_EMIT = 5'd26;

  typedef struct packed {
    logic [1:0]       shape_kind;
    logic [15:0]      size_a;
    logic [15:0]      size_b;
    logic [3:0][31:0] bezier_point;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic k_last;
    logic i_last;
    logic bk_last;
  } status_t;

  function automatic logic [DVS_W-1:0] sin_divisor(input logic [2:0] k);
    logic [DVS_W-1:0] d;
    case (k)
      3'd1:    d = 8'd6;
      3'd2:    d = 8'd20;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd72;
      3'd5:    d = 8'd110;
      3'd6:    d = 8'd156;
      3'd7:    d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  function automatic logic [DVS_W-1:0] cos_divisor(input logic [2:0] k);
    logic [DVS_W-1:0] d;
    case (k)
      3'd1:    d = 8'd2;
      3'd2:    d = 8'd12;
      3'd3:    d = 8'd30;
      3'd4:    d = 8'd56;
      3'd5:    d = 8'd90;
      3'd6:    d = 8'd132;
      3'd7:    d = 8'd182;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  function automatic logic [BZ_W_W-1:0] bz_weight(input logic [BZ_IW-1:0] i,
                                                  input logic [1:0] k);
    logic [BZ_W_W-1:0] a;
    logic [BZ_W_W-1:0] b;
    logic [BZ_W_W-1:0] w;
    a = BZ_W_W'(BEZIER_SAMPLES) - BZ_W_W'(i);
    b = BZ_W_W'(i);
    unique case (k)
      2'd0: w = BZ_W_W'(a * a * a);
      2'd1: w = BZ_W_W'(3 * a * a * b);
      2'd2: w = BZ_W_W'(3 * a * b * b);
      2'd3: w = BZ_W_W'(b * b * b);
    endcase
    return w;
  endfunction

endpackage

[src/shape_vertex_generator.sv]
// ----------------------------------------------------------------------------
// shape_vertex_generator
// circle, rectangle and cubic bezier vertex and index generator
// ----------------------------------------------------------------------------
// rectangle: 6 results, one a cycle, from the S_RECT state that follows the load
// bezier: 8 results (four multiply-accumulates per sample)
// circle: one result per rim vertex plus one for the closing index;
//   the 15 divisions of each vertex run on the 4-bit-per-cycle divider
// results are never stalled; reset clears configuration to a rectangle, idle
`timescale 1ns / 1ps

module shape_vertex_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [31:0]        in_depth_z,
  input  logic [15:0]        in_first_vertex_slot,
  input  logic [15:0]        in_first_index_slot,
  output logic               out_strobe,
  output logic               out_vertex_valid,
  output logic [16:0]        out_vertex_slot,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_pos_z,
  output logic signed [31:0] out_tex_u,
  output logic signed [31:0] out_tex_v,
  output logic               out_index_valid,
  output logic [16:0]        out_index_slot,
  output logic [16:0]        out_index_value,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import svg_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape_kind   <= KIND_RECT;
      cfg_r.size_a       <= '0;
      cfg_r.size_b       <= '0;
      cfg_r.bezier_point <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_KIND:   cfg_r.shape_kind      <= pwdata[1:0];
        REG_SIZE_A: cfg_r.size_a          <= pwdata[15:0];
        REG_SIZE_B: cfg_r.size_b          <= pwdata[15:0];
        REG_BZ0:    cfg_r.bezier_point[0] <= pwdata;
        REG_BZ1:    cfg_r.bezier_point[1] <= pwdata;
        REG_BZ2:    cfg_r.bezier_point[2] <= pwdata;
        REG_BZ3:    cfg_r.bezier_point[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KIND:   prdata = {30'b0, cfg_r.shape_kind};
      REG_SIZE_A: prdata = {16'b0, cfg_r.size_a};
      REG_SIZE_B: prdata = {16'b0, cfg_r.size_b};
      REG_BZ0:    prdata = cfg_r.bezier_point[0];
      REG_BZ1:    prdata = cfg_r.bezier_point[1];
      REG_BZ2:    prdata = cfg_r.bezier_point[2];
      REG_BZ3:    prdata = cfg_r.bezier_point[3];
      default:    prdata = '0;
    endcase
  end

  svg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .shape_kind (cfg_r.shape_kind),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  svg_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg                  (cfg_r),
    .in_origin_x          (in_origin_x),
    .in_origin_y          (in_origin_y),
    .in_depth_z           (in_depth_z),
    .in_first_vertex_slot (in_first_vertex_slot),
    .in_first_index_slot  (in_first_index_slot),
    .status               (status),
    .out_strobe           (out_strobe),
    .out_vertex_valid     (out_vertex_valid),
    .out_vertex_slot      (out_vertex_slot),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_pos_z            (out_pos_z),
    .out_tex_u            (out_tex_u),
    .out_tex_v            (out_tex_v),
    .out_index_valid      (out_index_valid),
    .out_index_slot       (out_index_slot),
    .out_index_value      (out_index_value),
    .out_last             (out_last)
  );

endmodule

[src/svg_div.sv]
// ----------------------------------------------------------------------------
// svg_div
// iterative unsigned divider, four quotient bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svg_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [svg_pkg::DIV_W-1:0] dividend,
  input  logic [svg_pkg::DVS_W-1:0] divisor,
  output logic                     done,
  output logic [svg_pkg::DIV_W-1:0] quotient
);
  import svg_pkg::*;

  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;

  always_comb begin
    logic [DVS_W:0] t;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    for (int j = 0; j < DIV_RADIX; j++) begin
      t = {rem_nxt, dq_nxt[DIV_W-1]};
      if (t >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(t - {1'b0, dvs_r});
        dq_nxt  = {dq_nxt[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = t[DVS_W-1:0];
        dq_nxt  = {dq_nxt[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= DIV_CW'(cnt_r + 1'b1);
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

[src/svg_datapath.sv]
// ----------------------------------------------------------------------------
// svg_datapath
// shared multiplier, divider, trig series and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svg_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  svg_pkg::cmd_t           cmd,
  input  svg_pkg::cfg_t           cfg,
  input  logic signed [15:0]      in_origin_x,
  input  logic signed [15:0]      in_origin_y,
  input  logic [31:0]             in_depth_z,
  input  logic [15:0]             in_first_vertex_slot,
  input  logic [15:0]             in_first_index_slot,
  output svg_pkg::status_t        status,
  output logic                    out_strobe,
  output logic                    out_vertex_valid,
  output logic [16:0]             out_vertex_slot,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic [31:0]             out_pos_z,
  output logic signed [31:0]      out_tex_u,
  output logic signed [31:0]      out_tex_v,
  output logic                    out_index_valid,
  output logic [16:0]             out_index_slot,
  output logic [16:0]             out_index_value,
  output logic                    out_last
);
  import svg_pkg::*;

  localparam logic signed [33:0] Q30_ONE_S = 34'sd1 <<< 30;
  localparam logic [32:0]        Q30_ONE_U = 33'd1 << 30;
  localparam int                 FS_W      = BZ_ACC_W + FRAC_BITS + 1;

  logic signed [15:0] ox_r, oy_r;
  logic [31:0]        z_r;
  logic [15:0]        vs_r, is_r;
  logic [SEG_W-1:0]   n_r;
  logic [IDX_W-1:0]   i_r;
  logic [2:0]         k_r;
  logic [1:0]         bk_r;
  logic [31:0]        phase_r;
  logic [30:0]        x_r;
  logic [31:0]        x2_r;
  logic [32:0]        ts_r, tc_r;
  logic signed [33:0] sn_r, cs_r, c_r, s_r;
  logic [63:0]        prod_r;
  logic signed [31:0] ix_r, iy_r;
  logic [BZ_ACC_W-1:0] accx_r, accy_r;

  logic                strobe_r;
  logic                vval_r, ival_r, last_r;
  logic [16:0]         vslot_r, islot_r, ival_v_r;
  logic signed [31:0]  px_r, py_r, tu_r, tv_r;
  logic [31:0]         pz_r;

  logic [SEG_W-1:0]   n_clamp;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_nxt;
  logic [33:0]        c_mag, s_mag;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [DVS_W-1:0]   div_divisor;
  logic signed [33:0] term_s;
  logic [BZ_W_W-1:0]  bz_w;
  logic [31:0]        bz_pt;
  logic signed [31:0] ox_fx, oy_fx;
  logic               rc_x, rc_y;
  logic [2:0]         r_off;
  logic signed [31:0] rect_x, rect_y;
  logic [FS_W-1:0]    fsx, fsy;
  logic signed [31:0] fx, fy;
  logic               i_last;

  function automatic logic signed [31:0] round_off(input logic [63:0] p, input logic neg);
    logic [48:0] sum;
    logic [31:0] mag;
    sum = {1'b0, p[47:0]} + (49'd1 << (RND_SH - 1));
    mag = 32'(sum >> RND_SH);
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

  always_comb begin
    if (cfg.size_b == 16'd0) begin
      n_clamp = SEG_W'(1);
    end else if (cfg.size_b > 16'(MAX_SEGMENTS)) begin
      n_clamp = SEG_W'(MAX_SEGMENTS);
    end else begin
      n_clamp = cfg.size_b[SEG_W-1:0];
    end
  end

  assign c_mag = c_r[33] ? 34'(-c_r) : 34'(c_r);
  assign s_mag = s_r[33] ? 34'(-s_r) : 34'(s_r);
  assign bz_w  = bz_weight(i_r[BZ_IW-1:0], bk_r);
  assign bz_pt = cfg.bezier_point[bk_r];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_X: begin
        mul_a = {2'b0, phase_r[29:0]};
        mul_b = HALF_PI_Q30;
      end
      OP_MUL_X2: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
      end
      OP_MUL_TS: begin
        mul_a = ts_r[31:0];
        mul_b = x2_r;
      end
      OP_MUL_TC: begin
        mul_a = tc_r[31:0];
        mul_b = x2_r;
      end
      OP_MUL_OX: begin
        mul_a = c_mag[31:0];
        mul_b = {16'b0, cfg.size_a};
      end
      OP_MUL_OY: begin
        mul_a = s_mag[31:0];
        mul_b = {16'b0, cfg.size_a};
      end
      OP_BZ_MX: begin
        mul_a = 32'(bz_w);
        mul_b = {16'b0, bz_pt[15:0]};
      end
      OP_BZ_MY: begin
        mul_a = 32'(bz_w);
        mul_b = {16'b0, bz_pt[31:16]};
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd.op)
      OP_PH_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({i_r, 32'b0});
        div_divisor  = DVS_W'(n_r);
      end
      OP_DIV_TS: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(prod_r[62:30]);
        div_divisor  = sin_divisor(k_r);
      end
      OP_DIV_TC: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(prod_r[62:30]);
        div_divisor  = cos_divisor(k_r);
      end
      default: ;
    endcase
  end

  svg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign term_s = signed'({1'b0, div_q[32:0]});

  assign ox_fx = 32'(ox_r) <<< FRAC_BITS;
  assign oy_fx = 32'(oy_r) <<< FRAC_BITS;

  always_comb begin
    rc_x  = 1'b0;
    rc_y  = 1'b0;
    r_off = 3'd0;
    case (i_r[2:0])
      3'd0: begin rc_y = 1'b1; r_off = 3'd0; end
      3'd1: begin r_off = 3'd1; end
      3'd2: begin rc_x = 1'b1; r_off = 3'd2; end
      3'd3: begin rc_x = 1'b1; rc_y = 1'b1; r_off = 3'd0; end
      3'd4: begin r_off = 3'd2; end
      3'd5: begin r_off = 3'd3; end
      default: ;
    endcase
  end

  assign rect_x = (32'(ox_r) + (rc_x ? signed'({16'b0, cfg.size_a}) : 32'sd0)) <<< FRAC_BITS;
  assign rect_y = (32'(oy_r) + (rc_y ? signed'({16'b0, cfg.size_b}) : 32'sd0)) <<< FRAC_BITS;

  assign fsx = FS_W'({accx_r, {FRAC_BITS{1'b0}}}) + (FS_W'(1) << (BZ_SH - 1));
  assign fsy = FS_W'({accy_r, {FRAC_BITS{1'b0}}}) + (FS_W'(1) << (BZ_SH - 1));
  assign fx  = signed'(32'(fsx >> BZ_SH));
  assign fy  = signed'(32'(fsy >> BZ_SH));

  always_comb begin
    unique case (cfg.shape_kind)
      KIND_CIRCLE: i_last = (i_r == IDX_W'(n_r - 1'b1));
      KIND_RECT:   i_last = (i_r == IDX_W'(RECT_RESULTS - 1));
      KIND_BEZIER: i_last = (i_r == IDX_W'(BEZIER_SAMPLES - 1));
      default:     i_last = 1'b1;
    endcase
  end

  assign status.div_done = div_done;
  assign status.k_last   = (k_r == 3'd7);
  assign status.i_last   = i_last;
  assign status.bk_last  = (bk_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == OP_EMIT_C) || (cmd.op == OP_CLOSE) ||
                  (cmd.op == OP_RECT) || (cmd.op == OP_BZ_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ox_r <= in_origin_x;
        oy_r <= in_origin_y;
        z_r  <= in_depth_z;
        vs_r <= in_first_vertex_slot;
        is_r <= in_first_index_slot;
        n_r  <= n_clamp;
        i_r  <= '0;
      end
      OP_PH_WB: phase_r <= div_q[31:0];
      OP_MUL_X, OP_MUL_X2, OP_MUL_TS, OP_MUL_TC, OP_MUL_OX, OP_MUL_OY, OP_BZ_MX: begin
        prod_r <= prod_nxt;
      end
      OP_WB_X: x_r <= prod_r[60:30];
      OP_WB_X2: begin
        x2_r <= prod_r[61:30];
        ts_r <= {2'b0, x_r};
        tc_r <= Q30_ONE_U;
        sn_r <= signed'({3'b0, x_r});
        cs_r <= Q30_ONE_S;
        k_r  <= 3'd1;
      end
      OP_WB_TS: begin
        ts_r <= div_q[32:0];
        sn_r <= k_r[0] ? 34'(sn_r - term_s) : 34'(sn_r + term_s);
      end
      OP_WB_TC: begin
        tc_r <= div_q[32:0];
        cs_r <= k_r[0] ? 34'(cs_r - term_s) : 34'(cs_r + term_s);
        k_r  <= 3'(k_r + 1'b1);
      end
      OP_QUAD: begin
        unique case (phase_r[31:30])
          2'd0: begin c_r <= cs_r;  s_r <= sn_r;  end
          2'd1: begin c_r <= -sn_r; s_r <= cs_r;  end
          2'd2: begin c_r <= -cs_r; s_r <= -sn_r; end
          2'd3: begin c_r <= sn_r;  s_r <= -cs_r; end
        endcase
      end
      OP_WB_OX: ix_r <= round_off(prod_r, c_r[33]);
      OP_WB_OY: iy_r <= round_off(prod_r, s_r[33]);
      OP_EMIT_C: begin
        vval_r   <= 1'b1;
        vslot_r  <= {1'b0, vs_r} + 17'(i_r);
        px_r     <= ox_fx + ix_r;
        py_r     <= oy_fx + iy_r;
        pz_r     <= z_r;
        tu_r     <= ix_r;
        tv_r     <= iy_r;
        ival_r   <= 1'b1;
        islot_r  <= {1'b0, is_r} + 17'(i_r);
        ival_v_r <= {1'b0, vs_r} + 17'(i_r);
        last_r   <= 1'b0;
        i_r      <= IDX_W'(i_r + 1'b1);
      end
      OP_CLOSE: begin
        vval_r   <= 1'b0;
        vslot_r  <= '0;
        px_r     <= '0;
        py_r     <= '0;
        pz_r     <= '0;
        tu_r     <= '0;
        tv_r     <= '0;
        ival_r   <= 1'b1;
        islot_r  <= {1'b0, is_r} + 17'(n_r);
        ival_v_r <= {1'b0, vs_r};
        last_r   <= 1'b1;
      end
      OP_RECT: begin
        vval_r   <= (i_r < IDX_W'(4));
        vslot_r  <= (i_r < IDX_W'(4)) ? {1'b0, vs_r} + 17'(i_r) : '0;
        px_r     <= (i_r < IDX_W'(4)) ? rect_x : '0;
        py_r     <= (i_r < IDX_W'(4)) ? rect_y : '0;
        pz_r     <= (i_r < IDX_W'(4)) ? z_r : '0;
        tu_r     <= (i_r < IDX_W'(4) && rc_x) ? 32'sd1 <<< FRAC_BITS : '0;
        tv_r     <= (i_r < IDX_W'(4) && rc_y) ? 32'sd1 <<< FRAC_BITS : '0;
        ival_r   <= 1'b1;
        islot_r  <= {1'b0, is_r} + 17'(i_r);
        ival_v_r <= {1'b0, vs_r} + 17'(r_off);
        last_r   <= i_last;
        i_r      <= IDX_W'(i_r + 1'b1);
      end
      OP_BZ_CLR: begin
        accx_r <= '0;
        accy_r <= '0;
        bk_r   <= 2'd0;
      end
      OP_BZ_MY: begin
        accx_r <= BZ_ACC_W'(accx_r + prod_r[BZ_ACC_W-1:0]);
        prod_r <= prod_nxt;
      end
      OP_BZ_ACC: begin
        accy_r <= BZ_ACC_W'(accy_r + prod_r[BZ_ACC_W-1:0]);
        bk_r   <= 2'(bk_r + 1'b1);
      end
      OP_BZ_EMIT: begin
        vval_r   <= 1'b1;
        vslot_r  <= {1'b0, vs_r} + 17'(i_r);
        px_r     <= ox_fx + fx;
        py_r     <= oy_fx + fy;
        pz_r     <= z_r;
        tu_r     <= '0;
        tv_r     <= '0;
        ival_r   <= 1'b1;
        islot_r  <= {1'b0, is_r} + 17'(i_r);
        ival_v_r <= {1'b0, vs_r} + 17'(i_r);
        last_r   <= i_last;
        i_r      <= IDX_W'(i_r + 1'b1);
      end
      default: ;
    endcase
  end

  assign out_strobe       = strobe_r;
  assign out_vertex_valid = vval_r;
  assign out_vertex_slot  = vslot_r;
  assign out_pos_x        = px_r;
  assign out_pos_y        = py_r;
  assign out_pos_z        = pz_r;
  assign out_tex_u        = tu_r;
  assign out_tex_v        = tv_r;
  assign out_index_valid  = ival_r;
  assign out_index_slot   = islot_r;
  assign out_index_value  = ival_v_r;
  assign out_last         = last_r;

endmodule

[src/svg_ctrl.sv]
// ----------------------------------------------------------------------------
// svg_ctrl
// sequencer that steps the datapath through one shape
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       shape_kind,
  input  svg_pkg::status_t status,
  output svg_pkg::cmd_t    cmd,
  output logic             busy
);
  import svg_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PH_DIV  = 5'd1;
  localparam logic [4:0] S_PH_WAIT = 5'd2;
  localparam logic [4:0] S_MUL_X   = 5'd3;
  localparam logic [4:0] S_WB_X    = 5'd4;
  localparam logic [4:0] S_MUL_X2  = 5'd5;
  localparam logic [4:0] S_WB_X2   = 5'd6;
  localparam logic [4:0] S_MUL_TS  = 5'd7;
  localparam logic [4:0] S_DIV_TS  = 5'd8;
  localparam logic [4:0] S_WAIT_TS = 5'd9;
  localparam logic [4:0] S_MUL_TC  = 5'd10;
  localparam logic [4:0] S_DIV_TC  = 5'd11;
  localparam logic [4:0] S_WAIT_TC = 5'd12;
  localparam logic [4:0] S_QUAD    = 5'd13;
  localparam logic [4:0] S_MUL_OX  = 5'd14;
  localparam logic [4:0] S_WB_OX   = 5'd15;
  localparam logic [4:0] S_MUL_OY  = 5'd16;
  localparam logic [4:0] S_WB_OY   = 5'd17;
  localparam logic [4:0] S_EMIT_C  = 5'd18;
  localparam logic [4:0] S_CLOSE   = 5'd19;
  localparam logic [4:0] S_RECT    = 5'd20;
  localparam logic [4:0] S_BZ_CLR  = 5'd21;
  localparam logic [4:0] S_BZ_MX   = 5'd22;
  localparam logic [4:0] S_BZ_MY   = 5'd23;
  localparam logic [4:0] S_BZ_ACC  = 5'd24;
  localparam logic [4:0] S_BZ_EMIT = 5'd25;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          unique case (shape_kind)
            KIND_CIRCLE: state_nxt = S_PH_DIV;
            KIND_RECT:   state_nxt = S_RECT;
            KIND_BEZIER: state_nxt = S_BZ_CLR;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_PH_DIV: begin
        cmd.op    = OP_PH_DIV;
        state_nxt = S_PH_WAIT;
      end
      S_PH_WAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_PH_WB;
          state_nxt = S_MUL_X;
        end
      end
      S_MUL_X:  begin cmd.op = OP_MUL_X;  state_nxt = S_WB_X;   end
      S_WB_X:   begin cmd.op = OP_WB_X;   state_nxt = S_MUL_X2; end
      S_MUL_X2: begin cmd.op = OP_MUL_X2; state_nxt = S_WB_X2;  end
      S_WB_X2:  begin cmd.op = OP_WB_X2;  state_nxt = S_MUL_TS; end
      S_MUL_TS: begin cmd.op = OP_MUL_TS; state_nxt = S_DIV_TS; end
      S_DIV_TS: begin cmd.op = OP_DIV_TS; state_nxt = S_WAIT_TS; end
      S_WAIT_TS: begin
        if (status.div_done) begin
          cmd.op    = OP_WB_TS;
          state_nxt = S_MUL_TC;
        end
      end
      S_MUL_TC: begin cmd.op = OP_MUL_TC; state_nxt = S_DIV_TC; end
      S_DIV_TC: begin cmd.op = OP_DIV_TC; state_nxt = S_WAIT_TC; end
      S_WAIT_TC: begin
        if (status.div_done) begin
          cmd.op    = OP_WB_TC;
          state_nxt = status.k_last ? S_QUAD : S_MUL_TS;
        end
      end
      S_QUAD:   begin cmd.op = OP_QUAD;   state_nxt = S_MUL_OX; end
      S_MUL_OX: begin cmd.op = OP_MUL_OX; state_nxt = S_WB_OX;  end
      S_WB_OX:  begin cmd.op = OP_WB_OX;  state_nxt = S_MUL_OY; end
      S_MUL_OY: begin cmd.op = OP_MUL_OY; state_nxt = S_WB_OY;  end
      S_WB_OY:  begin cmd.op = OP_WB_OY;  state_nxt = S_EMIT_C; end
      S_EMIT_C: begin
        cmd.op    = OP_EMIT_C;
        state_nxt = status.i_last ? S_CLOSE : S_PH_DIV;
      end
      S_CLOSE: begin
        cmd.op    = OP_CLOSE;
        state_nxt = S_IDLE;
      end
      S_RECT: begin
        cmd.op    = OP_RECT;
        state_nxt = status.i_last ? S_IDLE : S_RECT;
      end
      S_BZ_CLR: begin cmd.op = OP_BZ_CLR; state_nxt = S_BZ_MX; end
      S_BZ_MX:  begin cmd.op = OP_BZ_MX;  state_nxt = S_BZ_MY; end
      S_BZ_MY:  begin cmd.op = OP_BZ_MY;  state_nxt = S_BZ_ACC; end
      S_BZ_ACC: begin
        cmd.op    = OP_BZ_ACC;
        state_nxt = status.bk_last ? S_BZ_EMIT : S_BZ_MX;
      end
      S_BZ_EMIT: begin
        cmd.op    = OP_BZ_EMIT;
        state_nxt = status.i_last ? S_IDLE : S_BZ_CLR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[src/svg_checker.sv]
// ----------------------------------------------------------------------------
// svg_checker
// port-level checks of the shape vertex generator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shape_vertex_generator_defines.svh"

module svg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               pready,
  input logic               out_strobe,
  input logic               out_last,
  input logic               out_index_valid,
  input logic               out_vertex_valid,
  input logic [16:0]        out_vertex_slot,
  input logic signed [31:0] out_pos_x,
  input logic [31:0]        out_pos_z,
  input logic signed [31:0] out_tex_u
);

  `SVG_ASSERT_SAME(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")
  `SVG_ASSERT_SAME(a_index_each, clk, rst_n, out_strobe, out_index_valid, "result without index transfer")
  `SVG_ASSERT_SAME(a_empty_vertex, clk, rst_n, out_strobe && !out_vertex_valid, out_vertex_slot == 17'd0 && out_pos_x == 32'sd0 && out_pos_z == 32'd0 && out_tex_u == 32'sd0, "index-only result carries vertex data")
  `SVG_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_strobe && out_last, !out_strobe, "transfer right after last")
  `SVG_ASSERT_NEXT(a_no_early_result, clk, rst_n, start && !busy, !out_strobe, "transfer in the cycle after start")

endmodule

bind shape_vertex_generator svg_checker u_svg_checker (.*);
